// ===== rtl/core/irpw_pkg.sv =====
// shared types and constants for the infrared pulse-width capture block
// no dependencies; imported by every module under rtl/core

package irpw_pkg;

  // widths of the result fields and of the frame length
  localparam int unsigned DurWidth   = 16;
  localparam int unsigned IndexWidth = 7;
  localparam int unsigned PairsWidth = 8;

  // frame length clamp; the pair index is seven bits, so 128 is the ceiling
  localparam logic [PairsWidth-1:0] MaxPairs = 8'd128;

  // register reset values
  localparam logic [15:0]           MinFirstLowRst    = 16'd250;
  localparam logic [PairsWidth-1:0] PulsesPerFrameRst = 8'd114;

  // register indexes on the apb port
  localparam logic RegMinFirstLow    = 1'b0;
  localparam logic RegPulsesPerFrame = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    StPulse    = 2'd0,
    StComplete = 2'd1,
    StReject   = 2'd2
  } status_e;

  // configuration seen by the measuring logic
  typedef struct packed {
    logic [15:0]           min_first_low;
    logic [PairsWidth-1:0] pulses_per_frame;
  } cfg_t;

  // one result request
  typedef struct packed {
    logic [DurWidth-1:0]   duration;
    logic                  polarity;
    logic [IndexWidth-1:0] pulse_index;
    status_e               status;
    logic                  last;
  } result_t;

endpackage

// ===== rtl/core/irpw_regs.sv =====
// apb register file: min_first_low and pulses_per_frame
// depends on irpw_pkg

module irpw_regs
  import irpw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [15:0]           min_first_low_q;
  logic [PairsWidth-1:0] pulses_per_frame_q;
  logic                  wr_en;
  logic                  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_first_low_q    <= MinFirstLowRst;
      pulses_per_frame_q <= PulsesPerFrameRst;
    end else if (wr_en) begin
      if (reg_sel == RegMinFirstLow) begin
        min_first_low_q <= pwdata[15:0];
      end else begin
        pulses_per_frame_q <= pwdata[PairsWidth-1:0];
      end
    end
  end

  // read mux
  always_comb begin
    if (reg_sel == RegPulsesPerFrame) begin
      prdata = {{(32-PairsWidth){1'b0}}, pulses_per_frame_q};
    end else begin
      prdata = {16'd0, min_first_low_q};
    end
  end

  assign cfg_o.min_first_low    = min_first_low_q;
  assign cfg_o.pulses_per_frame = pulses_per_frame_q;

endmodule

// ===== rtl/core/irpw_step.sv =====
// pulse measuring state machine: one level sample per accepted request
// depends on irpw_pkg; produces at most one result request per sample

module irpw_step
  import irpw_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    take_i,
  input  logic    level_i,
  input  cfg_t    cfg_i,
  output logic    res_valid_o,
  output result_t res_o
);

  localparam int unsigned CmpWidth = (COUNT_WIDTH > DurWidth) ? COUNT_WIDTH : DurWidth;

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhLow  = 2'd1,
    PhHigh = 2'd2
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] tick_q, tick_d;
  logic [IndexWidth-1:0]  pair_q, pair_d;

  logic [CmpWidth-1:0]    tick_ext;
  logic [DurWidth-1:0]    dur_sat;
  logic [COUNT_WIDTH-1:0] tick_inc;
  logic [PairsWidth-1:0]  frame_pairs;
  logic                   short_first;
  logic                   frame_done;

  // saturating count and clamped duration
  assign tick_ext = CmpWidth'(tick_q);
  assign dur_sat  = (tick_ext > CmpWidth'({DurWidth{1'b1}})) ? {DurWidth{1'b1}}
                                                              : tick_ext[DurWidth-1:0];
  assign tick_inc = (tick_q == {COUNT_WIDTH{1'b1}}) ? tick_q
                                                     : tick_q + COUNT_WIDTH'(1);

  // frame length clamped to one..MaxPairs
  always_comb begin
    if (cfg_i.pulses_per_frame == '0) begin
      frame_pairs = PairsWidth'(1);
    end else if (cfg_i.pulses_per_frame > MaxPairs) begin
      frame_pairs = MaxPairs;
    end else begin
      frame_pairs = cfg_i.pulses_per_frame;
    end
  end

  assign short_first = (pair_q == '0) && (tick_ext < CmpWidth'(cfg_i.min_first_low));
  assign frame_done  = ({1'b0, pair_q} + PairsWidth'(1)) >= frame_pairs;

  // next state and result
  always_comb begin
    phase_d     = phase_q;
    tick_d      = tick_q;
    pair_d      = pair_q;
    res_valid_o = 1'b0;
    res_o.duration    = dur_sat;
    res_o.polarity    = 1'b0;
    res_o.pulse_index = pair_q;
    res_o.status      = StPulse;
    res_o.last        = 1'b0;
    if (take_i) begin
      case (phase_q)
        PhLow: begin
          if (!level_i) begin
            tick_d = tick_inc;
          end else begin
            res_valid_o = 1'b1;
            if (short_first) begin
              res_o.status = StReject;
              res_o.last   = 1'b1;
              phase_d      = PhIdle;
            end else if (frame_done) begin
              res_o.status = StComplete;
              res_o.last   = 1'b1;
              phase_d      = PhIdle;
            end else begin
              phase_d = PhHigh;
              tick_d  = COUNT_WIDTH'(1);
            end
          end
        end
        PhHigh: begin
          if (level_i) begin
            tick_d = tick_inc;
          end else begin
            res_valid_o    = 1'b1;
            res_o.polarity = 1'b1;
            pair_d         = pair_q + IndexWidth'(1);
            phase_d        = PhLow;
            tick_d         = COUNT_WIDTH'(1);
          end
        end
        default: begin
          // idle, and the unused code behaves the same
          phase_d = PhIdle;
          if (!level_i) begin
            phase_d = PhLow;
            tick_d  = COUNT_WIDTH'(1);
            pair_d  = '0;
          end
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      tick_q  <= '0;
      pair_q  <= '0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      pair_q  <= pair_d;
    end
  end

endmodule

// ===== rtl/core/irpw_outbuf.sv =====
// result register with a skid stage, which holds one more result while the output stalls
// depends on irpw_pkg

module irpw_outbuf
  import irpw_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_o
);

  logic    out_v_q, skid_v_q;
  result_t out_q, skid_q;
  logic    out_free;

  assign out_free    = !out_v_q || !out_stall_i;
  assign out_valid_o = out_v_q;
  assign out_o       = out_q;
  assign full_o      = skid_v_q;

  // control: output slot and skid slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q  <= skid_v_q || push_i;
      skid_v_q <= 1'b0;
    end else if (push_i) begin
      skid_v_q <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

endmodule

// ===== rtl/core/ir_pulse_width_capture.sv =====
// infrared pulse-width capture, top level
// result path: the result is registered into the output slot, or into the skid slot while the output stalls
// throughput: one level sample per cycle; input stalls only when both result slots are full
// reset: registers to min_first_low 250 and pulses_per_frame 114, state machine idle
// depends on irpw_pkg, irpw_regs, irpw_step, irpw_outbuf

module ir_pulse_width_capture
  import irpw_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        level_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] duration_o,
  output logic        polarity_o,
  output logic [6:0]  pulse_index_o,
  output logic [1:0]  status_o,
  output logic        last_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  logic    take;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    buf_full;

  assign in_stall_o = buf_full;
  assign take       = in_valid_i && !buf_full;

  // configuration registers
  irpw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // pulse measurement
  irpw_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .level_i     (level_i),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result buffering
  irpw_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .data_i      (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign duration_o    = out_res.duration;
  assign polarity_o    = out_res.polarity;
  assign pulse_index_o = out_res.pulse_index;
  assign status_o      = out_res.status;
  assign last_o        = out_res.last;

endmodule
